/* hw/rtl/d2pc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package d2pc_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH = 3'd0,
      CSR_CENTER_X    = 3'd1,
      CSR_CENTER_Y    = 3'd2,
      CSR_FOCAL_X     = 3'd3,
      CSR_FOCAL_Y     = 3'd4,
      CSR_DEPTH_SCALE = 3'd5
   } csr_index_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_MUL,
      BK_DIVZ,
      BK_DIVX,
      BK_DIVY,
      BK_SEND
   } back_state_type;

   localparam int unsigned DEPTH_W  = 16;
   localparam int unsigned COLOR_W  = 24;
   localparam int unsigned PARAM_W  = 16;
   localparam int unsigned WIDTH_W  = 13;
   localparam int unsigned DEN_W    = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned Z_W      = 31;
   localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [Z_W-1:0]     SAT_Z   = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

/* hw/rtl/d2pc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module d2pc_front #(
   parameter int unsigned COORD_BITS      = 12,
   parameter int unsigned DECIMATION_STEP = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [d2pc_pkg::WIDTH_W-1:0]      image_width,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic                              req_tuser,
   input  wire logic [39:0]                       req_tdata,
   input  wire logic                              ent_full,
   output logic                                   ent_push,
   output logic [2*COORD_BITS+d2pc_pkg::DEPTH_W+d2pc_pkg::COLOR_W-1:0] ent_data
);
   import d2pc_pkg::*;

   localparam int unsigned PH_W = (DECIMATION_STEP > 1) ? $clog2(DECIMATION_STEP) : 1;
   localparam logic [PH_W-1:0]       PH_LAST = PH_W'(DECIMATION_STEP - 1);
   localparam logic [COORD_BITS-1:0] MASK    = {COORD_BITS{1'b1}};
   localparam int unsigned CMP_W = (COORD_BITS + 1 > WIDTH_W) ? COORD_BITS + 1 : WIDTH_W;

   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in, cur_col, cur_row;
   logic [PH_W-1:0]       cph_ff, cph_in, rph_ff, rph_in, cur_cph, cur_rph;
   logic [WIDTH_W-1:0]    width_eff;
   logic [DEPTH_W-1:0]    depth;
   logic                  accept, hit, wrap;

   assign req_tready = !ent_full;
   assign accept     = req_tvalid && req_tready;
   assign depth      = req_tdata[DEPTH_W-1:0];

   always_comb begin
      // frame start restarts position before this pixel is classified
      cur_col   = req_tuser ? '0 : col_ff;
      cur_row   = req_tuser ? '0 : row_ff;
      cur_cph   = req_tuser ? '0 : cph_ff;
      cur_rph   = req_tuser ? '0 : rph_ff;
      width_eff = (image_width == '0) ? WIDTH_W'(1) : image_width;
      hit       = (cur_cph == '0) && (cur_rph == '0) && (depth != '0);
      wrap      = (cur_col == MASK) ||
                  ((CMP_W'(cur_col) + CMP_W'(1)) >= CMP_W'(width_eff));
      col_in = col_ff;
      row_in = row_ff;
      cph_in = cph_ff;
      rph_in = rph_ff;
      if (accept) begin
         if (wrap) begin
            col_in = '0;
            cph_in = '0;
            row_in = cur_row + COORD_BITS'(1);
            rph_in = (cur_row == MASK || cur_rph == PH_LAST) ? '0 : cur_rph + PH_W'(1);
         end else begin
            col_in = cur_col + COORD_BITS'(1);
            cph_in = (cur_cph == PH_LAST) ? '0 : cur_cph + PH_W'(1);
            row_in = cur_row;
            rph_in = cur_rph;
         end
      end
   end

   assign ent_push = accept && hit;
   assign ent_data = {req_tdata[39:16], depth, cur_row, cur_col};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/d2pc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module d2pc_fifo #(
   parameter int unsigned WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      pop_data
);
   import d2pc_pkg::*;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/d2pc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module d2pc_div #(
   parameter int unsigned NUM_W = 48
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [NUM_W-1:0]             numer,
   input  wire logic [d2pc_pkg::DEN_W-1:0]   denom,
   output logic                              done,
   output logic [NUM_W-1:0]                  quot
);
   import d2pc_pkg::*;

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             qbit;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], qbit};
         rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/d2pc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module d2pc_back #(
   parameter int unsigned COORD_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [d2pc_pkg::PARAM_W-1:0]   center_x,
   input  wire logic [d2pc_pkg::PARAM_W-1:0]   center_y,
   input  wire logic [d2pc_pkg::PARAM_W-1:0]   focal_x,
   input  wire logic [d2pc_pkg::PARAM_W-1:0]   focal_y,
   input  wire logic [d2pc_pkg::PARAM_W-1:0]   depth_scale,
   input  wire logic                           ent_valid,
   input  wire logic [2*COORD_BITS+d2pc_pkg::DEPTH_W+d2pc_pkg::COLOR_W-1:0] ent_data,
   output logic                                ent_pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [119:0]                        rsp_tdata
);
   import d2pc_pkg::*;

   localparam int unsigned POS_W  = COORD_BITS + 4;
   localparam int unsigned DIFF_W = (POS_W > PARAM_W) ? POS_W : PARAM_W;
   localparam int unsigned PROD_W = DIFF_W + DEPTH_W;
   localparam int unsigned NUM_W  = PROD_W + FRAC_W;

   back_state_type        state_ff, state_in;
   logic [COORD_BITS-1:0] col_ff, row_ff;
   logic [DEPTH_W-1:0]    d_ff;
   logic [COLOR_W-1:0]    bgr_ff;
   logic [DIFF_W-1:0]     dx_ff, dy_ff, px16, py16, cx_ext, cy_ext;
   logic                  nx_ff, ny_ff;
   logic [PROD_W-1:0]     px_ff, py_ff;
   logic [DEN_W-1:0]      denx_ff, deny_ff;
   logic [PARAM_W-1:0]    scale_eff, fx_eff, fy_eff;
   logic [Z_W-1:0]        z_ff;
   logic [COORD_W-1:0]    x_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [119:0]          rsp_data_ff;
   logic                  load, prep, mul, store_z, store_x, store_y, send;
   logic                  div_start, div_done;
   logic [NUM_W-1:0]      div_num, div_q;
   logic [DEN_W-1:0]      div_den;

   function automatic logic [COORD_W-1:0] clamp_xy(input logic [NUM_W-1:0] q,
                                                   input logic neg);
      logic big;
      big = |q[NUM_W-1:COORD_W-1];
      if (neg) begin
         clamp_xy = big ? SAT_NEG : COORD_W'(0) - q[COORD_W-1:0];
      end else begin
         clamp_xy = big ? SAT_POS : q[COORD_W-1:0];
      end
   endfunction

   assign scale_eff = (depth_scale == '0) ? PARAM_W'(1) : depth_scale;
   assign fx_eff    = (focal_x == '0) ? PARAM_W'(1) : focal_x;
   assign fy_eff    = (focal_y == '0) ? PARAM_W'(1) : focal_y;
   assign px16      = DIFF_W'({col_ff, 4'b0000});
   assign py16      = DIFF_W'({row_ff, 4'b0000});
   assign cx_ext    = DIFF_W'(center_x);
   assign cy_ext    = DIFF_W'(center_y);

   always_comb begin
      state_in  = state_ff;
      load      = 1'b0;
      prep      = 1'b0;
      mul       = 1'b0;
      store_z   = 1'b0;
      store_x   = 1'b0;
      store_y   = 1'b0;
      send      = 1'b0;
      div_start = 1'b0;
      div_num   = NUM_W'({d_ff, {FRAC_W{1'b0}}});
      div_den   = DEN_W'(scale_eff);
      case (state_ff)
         BK_IDLE: begin
            if (ent_valid) begin
               load     = 1'b1;
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            prep     = 1'b1;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            mul       = 1'b1;
            div_start = 1'b1;
            state_in  = BK_DIVZ;
         end
         BK_DIVZ: begin
            div_num = {px_ff, {FRAC_W{1'b0}}};
            div_den = denx_ff;
            if (div_done) begin
               store_z   = 1'b1;
               div_start = 1'b1;
               state_in  = BK_DIVX;
            end
         end
         BK_DIVX: begin
            div_num = {py_ff, {FRAC_W{1'b0}}};
            div_den = deny_ff;
            if (div_done) begin
               store_x   = 1'b1;
               div_start = 1'b1;
               state_in  = BK_DIVY;
            end
         end
         BK_DIVY: begin
            if (div_done) begin
               store_y  = 1'b1;
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               send     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign ent_pop = load;

   d2pc_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   logic [COORD_W-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff <= ent_data[COORD_BITS-1:0];
         row_ff <= ent_data[2*COORD_BITS-1:COORD_BITS];
         d_ff   <= ent_data[2*COORD_BITS+DEPTH_W-1:2*COORD_BITS];
         bgr_ff <= ent_data[2*COORD_BITS+DEPTH_W+COLOR_W-1:2*COORD_BITS+DEPTH_W];
      end
      if (prep) begin
         nx_ff <= px16 < cx_ext;
         ny_ff <= py16 < cy_ext;
         dx_ff <= (px16 < cx_ext) ? cx_ext - px16 : px16 - cx_ext;
         dy_ff <= (py16 < cy_ext) ? cy_ext - py16 : py16 - cy_ext;
      end
      if (mul) begin
         px_ff   <= PROD_W'(dx_ff) * PROD_W'(d_ff);
         py_ff   <= PROD_W'(dy_ff) * PROD_W'(d_ff);
         denx_ff <= DEN_W'(scale_eff) * DEN_W'(fx_eff);
         deny_ff <= DEN_W'(scale_eff) * DEN_W'(fy_eff);
      end
      if (store_z) begin
         z_ff <= (|div_q[NUM_W-1:Z_W]) ? SAT_Z : div_q[Z_W-1:0];
      end
      if (store_x) begin
         x_ff <= clamp_xy(div_q, nx_ff);
      end
      if (store_y) begin
         y_ff <= clamp_xy(div_q, ny_ff);
      end
      if (send) begin
         rsp_data_ff <= {1'b0, bgr_ff[23:16], bgr_ff[15:8], bgr_ff[7:0], z_ff, y_ff, x_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/depth_to_point_cloud_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Depth/BGR pixels to 3-D points. A pixel transfer is taken every cycle while the
// 2-entry queue has room; pixels that yield no point never reach the back end.
// The back end runs three divisions on one shared radix-2 divider, one quotient bit a
// cycle, on NUM_W-bit numerators, NUM_W = max(COORD_BITS + 4, 16) + 32; it finishes
// one point before it takes the next one from the queue.
// Reset (synchronous, active high) restores register defaults, zeroes row and column.
module depth_to_point_cloud_top #(
   parameter int unsigned COORD_BITS      = 12,
   parameter int unsigned DECIMATION_STEP = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // pixel input
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,   // frame_start
   input  wire logic [39:0]  req_tdata,   // depth_raw[15:0], blue_in, green_in, red_in
   // point output
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [119:0]      rsp_tdata,   // point_x, point_y, point_z[30:0], blue, green,
                                          // red, one zero pad bit
   // register write port
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [15:0]  csr_wdata
);
   import d2pc_pkg::*;

   localparam int unsigned ENT_W = 2 * COORD_BITS + DEPTH_W + COLOR_W;

   logic [WIDTH_W-1:0] width_ff;
   logic [PARAM_W-1:0] cx_ff, cy_ff, fx_ff, fy_ff, scale_ff;
   logic               ent_push, ent_full, ent_pop, ent_valid;
   logic [ENT_W-1:0]   ent_in, ent_out;

   // register file, no read-back: to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd640;
         cx_ff    <= 16'd5112;
         cy_ff    <= 16'd3832;
         fx_ff    <= 16'd8400;
         fy_ff    <= 16'd8400;
         scale_ff <= 16'd1000;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_CENTER_X:    cx_ff    <= csr_wdata;
            CSR_CENTER_Y:    cy_ff    <= csr_wdata;
            CSR_FOCAL_X:     fx_ff    <= csr_wdata;
            CSR_FOCAL_Y:     fy_ff    <= csr_wdata;
            CSR_DEPTH_SCALE: scale_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // front: track position, decimate, drop zero depth
   d2pc_front #(
      .COORD_BITS      (COORD_BITS),
      .DECIMATION_STEP (DECIMATION_STEP)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .image_width (width_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .ent_full    (ent_full),
      .ent_push    (ent_push),
      .ent_data    (ent_in)
   );

   // queue between front and back
   d2pc_fifo #(
      .WIDTH(ENT_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ent_push),
      .push_data (ent_in),
      .full      (ent_full),
      .pop       (ent_pop),
      .valid     (ent_valid),
      .pop_data  (ent_out)
   );

   // back: project and hold the point in the output register
   d2pc_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .center_x    (cx_ff),
      .center_y    (cy_ff),
      .focal_x     (fx_ff),
      .focal_y     (fy_ff),
      .depth_scale (scale_ff),
      .ent_valid   (ent_valid),
      .ent_data    (ent_out),
      .ent_pop     (ent_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // nonzero depth over a 16-bit scale always gives z of at least one LSB
   a_z_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[94:64] != 31'd0))
      else $error("point with zero depth");

   // front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ent_push |-> !ent_full)
      else $error("queue overflow");

   // back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ent_pop |-> ent_valid)
      else $error("queue underflow");

endmodule
`default_nettype wire
